// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent assertions clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define ASSERT_AT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);

// Common form: the block clock clk and its reset rst_n.
`define ASSERT_CLK(label, prop, msg) \
    `ASSERT_AT(label, clk, rst_n, prop, msg)

`endif

// File: rtl/ocf_pkg.sv
// ----------------------------------------------------------------------------
// Outline curve flattener package
// Shared constants, element kind codes and Bernstein weight table.
// ----------------------------------------------------------------------------
package ocf_pkg;

    // Default coordinate width in bits, signed two's complement.
    localparam int COORD_WIDTH_DEF = 24;

    // Extra bits carried by the weighted sums above the coordinate width.
    localparam int SUM_GUARD = 8;

    // The weights are sixty-fourths, so the sum is scaled back by six bits.
    localparam int BERN_SHIFT = 6;
    localparam int BERN_HALF  = 32;
    localparam int WEIGHT_W   = 6;

    // Curve points between start and end (t = 1/4, 1/2, 3/4).
    localparam int NUM_MID_PTS = 3;
    // Control points of a cubic: start, ctrl1, ctrl2, end.
    localparam int NUM_CTRL    = 4;
    // Points in the segment chain of a curve: start, three mid points, end.
    localparam int NUM_CHAIN   = 5;

    typedef enum logic {
        KIND_CORNER = 1'b0,
        KIND_CURVE  = 1'b1
    } kind_t;

    // Weights applied to start, ctrl1, ctrl2 and end, one row per mid point.
    localparam logic [WEIGHT_W-1:0] BERN_W [NUM_MID_PTS][NUM_CTRL] = '{
        '{6'd27, 6'd27, 6'd9,  6'd1},
        '{6'd8,  6'd24, 6'd24, 6'd8},
        '{6'd1,  6'd9,  6'd27, 6'd27}
    };

endpackage

// File: rtl/outline_curve_flattener_top.sv
// ----------------------------------------------------------------------------
// Outline curve flattener
// Turns traced outline elements (corners and cubic curves) into line segments.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one outline element per
// transfer. A corner yields two segments and a cubic curve yields four; each
// segment leaves on the output channel (out_valid / out_stall) as one
// transfer, with last set on the final segment of the element.
// The first segment of an element is offered once the element has passed
// through the input register and into the result register, with the output
// side free.
// Throughput: one segment per cycle while the receiver does not stall; the
// single output port is what sets this rate. The next element is taken into
// the input register while the current one is still being sent, and its
// points are computed as the last segment leaves.
// Reset clears the kept start point to zero and empties both stages.
// When the receiver stalls, the offered segment holds still and the input
// side stalls as soon as the input register is occupied.
// ----------------------------------------------------------------------------
module outline_curve_flattener_top #(
    parameter int COORD_WIDTH = ocf_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic                          path_first,
    input  logic signed [COORD_WIDTH-1:0] close_x,
    input  logic signed [COORD_WIDTH-1:0] close_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl1_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl1_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl2_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl2_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] from_x,
    output logic signed [COORD_WIDTH-1:0] from_y,
    output logic signed [COORD_WIDTH-1:0] to_x,
    output logic signed [COORD_WIDTH-1:0] to_y,
    output logic                          last
);

    import ocf_pkg::*;

    localparam int SUM_W = COORD_WIDTH + SUM_GUARD;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]       wsum_t;

    // Start point carried from one element to the next.
    coord_t start_x_reg, start_x_next;
    coord_t start_y_reg, start_y_next;

    // Input register: element kind and its four control points, with the
    // start point already resolved against path_first.
    logic   a_valid_reg, a_valid_next;
    logic   a_curve_reg;
    coord_t a_px_reg [NUM_CTRL];
    coord_t a_py_reg [NUM_CTRL];

    // Result register: the chain of points still to be sent. The offered
    // segment always runs from entry 0 to entry 1; each transfer shifts the
    // chain down by one. b_rem_reg counts the segments after the current one.
    logic       b_valid_reg, b_valid_next;
    logic [1:0] b_rem_reg, b_rem_next;
    coord_t     b_x_reg [NUM_CHAIN];
    coord_t     b_y_reg [NUM_CHAIN];
    coord_t     b_x_next [NUM_CHAIN];
    coord_t     b_y_next [NUM_CHAIN];

    // Chain computed from the input register.
    coord_t chain_x [NUM_CHAIN];
    coord_t chain_y [NUM_CHAIN];
    coord_t mid_x [NUM_MID_PTS];
    coord_t mid_y [NUM_MID_PTS];

    logic in_fire;
    logic out_fire;
    logic b_last;
    logic b_free;
    logic a_move;

    // ------------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------------
    // The result register frees up when it is empty or when its final segment
    // is being taken; only then may the input register hand its element over.
    assign out_fire = b_valid_reg && !out_stall;
    assign b_last   = (b_rem_reg == '0);
    assign b_free   = !b_valid_reg || (out_fire && b_last);
    assign a_move   = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign in_fire  = in_valid && !in_stall;

    assign a_valid_next = in_fire || (a_valid_reg && !a_move);
    assign b_valid_next = a_move || (b_valid_reg && !b_free);

    // The kept start becomes the end point of every accepted element.
    always_comb
    begin
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        if (in_fire)
        begin
            start_x_next = end_x;
            start_y_next = end_y;
        end
    end

    // ------------------------------------------------------------------------
    // Curve evaluation: three weighted sums per axis, rounded to nearest with
    // ties toward plus infinity by adding half and taking the floor.
    // ------------------------------------------------------------------------
    always_comb
    begin
        wsum_t sum_x;
        wsum_t sum_y;
        wsum_t wgt;
        for (int j = 0; j < NUM_MID_PTS; j++)
        begin
            sum_x = wsum_t'(BERN_HALF);
            sum_y = wsum_t'(BERN_HALF);
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                wgt   = $signed({{(SUM_W-WEIGHT_W){1'b0}}, BERN_W[j][i]});
                sum_x = sum_x + wgt * wsum_t'(a_px_reg[i]);
                sum_y = sum_y + wgt * wsum_t'(a_py_reg[i]);
            end
            mid_x[j] = sum_x[BERN_SHIFT +: COORD_WIDTH];
            mid_y[j] = sum_y[BERN_SHIFT +: COORD_WIDTH];
        end
    end

    // A corner chain is start, corner, end; the unused tail repeats the end.
    always_comb
    begin
        chain_x[0] = a_px_reg[0];
        chain_y[0] = a_py_reg[0];
        if (a_curve_reg == KIND_CURVE)
        begin
            for (int k = 0; k < NUM_MID_PTS; k++)
            begin
                chain_x[k+1] = mid_x[k];
                chain_y[k+1] = mid_y[k];
            end
        end
        else
        begin
            chain_x[1] = a_px_reg[2];
            chain_y[1] = a_py_reg[2];
            chain_x[2] = a_px_reg[3];
            chain_y[2] = a_py_reg[3];
            chain_x[3] = a_px_reg[3];
            chain_y[3] = a_py_reg[3];
        end
        chain_x[NUM_CHAIN-1] = a_px_reg[3];
        chain_y[NUM_CHAIN-1] = a_py_reg[3];
    end

    // Result register next values: load a new chain, or shift on a transfer.
    always_comb
    begin
        b_rem_next = b_rem_reg;
        for (int k = 0; k < NUM_CHAIN; k++)
        begin
            b_x_next[k] = b_x_reg[k];
            b_y_next[k] = b_y_reg[k];
        end
        if (a_move)
        begin
            b_rem_next = (a_curve_reg == KIND_CURVE) ? 2'd3 : 2'd1;
            for (int k = 0; k < NUM_CHAIN; k++)
            begin
                b_x_next[k] = chain_x[k];
                b_y_next[k] = chain_y[k];
            end
        end
        else if (out_fire)
        begin
            b_rem_next = b_rem_reg - 2'd1;
            for (int k = 0; k < NUM_CHAIN - 1; k++)
            begin
                b_x_next[k] = b_x_reg[k+1];
                b_y_next[k] = b_y_reg[k+1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_rem_reg   <= '0;
        end
        else
        begin
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_rem_reg   <= b_rem_next;
        end
    end

    // Payload of the input register; the start comes from the closing point
    // on a path's first element and from the kept start otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_curve_reg <= kind;
            a_px_reg[0] <= path_first ? close_x : start_x_reg;
            a_py_reg[0] <= path_first ? close_y : start_y_reg;
            a_px_reg[1] <= ctrl1_x;
            a_py_reg[1] <= ctrl1_y;
            a_px_reg[2] <= ctrl2_x;
            a_py_reg[2] <= ctrl2_y;
            a_px_reg[3] <= end_x;
            a_py_reg[3] <= end_y;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CHAIN; k++)
        begin
            b_x_reg[k] <= b_x_next[k];
            b_y_reg[k] <= b_y_next[k];
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign out_valid = b_valid_reg;
    assign from_x    = b_x_reg[0];
    assign from_y    = b_y_reg[0];
    assign to_x      = b_x_reg[1];
    assign to_y      = b_y_reg[1];
    assign last      = b_last;

endmodule

// File: rtl/ocf_checker.sv
// ----------------------------------------------------------------------------
// Outline curve flattener checker
// Port-level assertions on the flattener, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocf_checker #(
    parameter int COORD_WIDTH = ocf_pkg::COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH-1:0] from_x,
    input logic signed [COORD_WIDTH-1:0] from_y,
    input logic signed [COORD_WIDTH-1:0] to_x,
    input logic signed [COORD_WIDTH-1:0] to_y,
    input logic                          last
);

    import ocf_pkg::*;

    logic out_xfer;

    assign out_xfer = out_valid && !out_stall;

    // A stalled segment stays offered and unchanged.
    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(from_x) && $stable(from_y) && $stable(to_x) && $stable(to_y) && $stable(last), "stalled segment changed")

    // Segments of one element are chained: each starts where the last ended.
    `ASSERT_CLK(a_seg_chain, out_xfer && !last |=> out_valid && from_x == $past(to_x) && from_y == $past(to_y), "segment chain broken")

    // With nothing offered at the output, the input side is never held off.
    `ASSERT_CLK(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled while output empty")

    // A segment is offered only after its element has passed the input register.
    `ASSERT_CLK(a_fill_latency, !out_valid && !$past(in_valid && !in_stall) |=> !out_valid || $past(out_valid) || $past(in_stall), "segment appeared without an element")

endmodule

bind outline_curve_flattener_top ocf_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_ocf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .last      (last)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Outline curve flattener testbench
// Feeds corners and cubic curves through the flattener and checks every
// segment against a cycle-free model of the pen position and the curve
// weights. A short table of hand-picked elements runs first, then random
// paths with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import ocf_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Items in the random part, and the stretch in which the receiver holds
    // off while the sender keeps offering.
    localparam int RANDOM_ITEMS = 95;
    localparam int HOLD_CYCLES  = 120;
    localparam int BURST_AT     = 35;
    localparam int BURST_LEN    = 12;
    localparam int PAUSE_AT     = 70;
    localparam int STEADY_FROM  = 78;
    localparam int STEADY_TO    = 92;
    localparam int DRAIN_CYCLES = 12;
    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        kind_t                 kind;
        logic                  path_first;
        logic signed [CW-1:0]  close_x;
        logic signed [CW-1:0]  close_y;
        logic signed [CW-1:0]  ctrl1_x;
        logic signed [CW-1:0]  ctrl1_y;
        logic signed [CW-1:0]  ctrl2_x;
        logic signed [CW-1:0]  ctrl2_y;
        logic signed [CW-1:0]  end_x;
        logic signed [CW-1:0]  end_y;
    } element_t;

    typedef struct packed {
        logic signed [CW-1:0]  from_x;
        logic signed [CW-1:0]  from_y;
        logic signed [CW-1:0]  to_x;
        logic signed [CW-1:0]  to_y;
        logic                  last;
    } segment_t;

    // A row of the directed table: the element, and how many segments were
    // typed in for it by hand (zero means the model supplies them).
    typedef struct {
        element_t  e;
        int        typed_n;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic                  path_first;
    logic signed [CW-1:0]  close_x;
    logic signed [CW-1:0]  close_y;
    logic signed [CW-1:0]  ctrl1_x;
    logic signed [CW-1:0]  ctrl1_y;
    logic signed [CW-1:0]  ctrl2_x;
    logic signed [CW-1:0]  ctrl2_y;
    logic signed [CW-1:0]  end_x;
    logic signed [CW-1:0]  end_y;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [CW-1:0]  from_x;
    logic signed [CW-1:0]  from_y;
    logic signed [CW-1:0]  to_x;
    logic signed [CW-1:0]  to_y;
    logic                  last;

    outline_curve_flattener_top #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .path_first (path_first),
        .close_x    (close_x),
        .close_y    (close_y),
        .ctrl1_x    (ctrl1_x),
        .ctrl1_y    (ctrl1_y),
        .ctrl2_x    (ctrl2_x),
        .ctrl2_y    (ctrl2_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .from_x     (from_x),
        .from_y     (from_y),
        .to_x       (to_x),
        .to_y       (to_y),
        .last       (last)
    );

    // The model's own copy of the pen position, and the segments that are
    // owed by the block, oldest first.
    logic signed [CW-1:0]  pen_x;
    logic signed [CW-1:0]  pen_y;
    segment_t              pending_segs [$];
    segment_t              typed_segs [$];
    plan_row_t             directed_rows [$];

    int  error_count;
    int  seg_checked;
    int  elem_sent;
    int  corner_sent;
    int  curve_sent;
    int  path_starts;

    // Handshake flags shared between the sender and the receiver.
    bit  hold_req;
    bit  steady;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // One point on the cubic at t = phase/4, weights in sixty-fourths,
    // rounded to nearest with ties upward.
    function automatic logic signed [CW-1:0] curve_coord(input int phase,
                                                         input longint p0,
                                                         input longint p1,
                                                         input longint p2,
                                                         input longint p3);
        longint acc;
        case (phase)
            1:       acc = 27 * p0 + 27 * p1 + 9 * p2 + p3;
            2:       acc = 8 * p0 + 24 * p1 + 24 * p2 + 8 * p3;
            default: acc = p0 + 9 * p1 + 27 * p2 + 27 * p3;
        endcase
        acc = (acc + 32) >>> 6;
        return acc[CW-1:0];
    endfunction

    // Advances the pen over one element. When keep is set, the segments it
    // yields are queued as owed by the block.
    task automatic flatten_element(input element_t e, input bit keep);
        logic signed [CW-1:0] px [5];
        logic signed [CW-1:0] py [5];
        int                   nseg;
        int                   k;
        segment_t             s;
        if (e.path_first)
        begin
            pen_x = e.close_x;
            pen_y = e.close_y;
        end
        px[0] = pen_x;
        py[0] = pen_y;
        if (e.kind == KIND_CORNER)
        begin
            px[1] = e.ctrl2_x;
            py[1] = e.ctrl2_y;
            px[2] = e.end_x;
            py[2] = e.end_y;
            nseg  = 2;
        end
        else
        begin
            for (k = 1; k <= 3; k++)
            begin
                px[k] = curve_coord(k, pen_x, e.ctrl1_x, e.ctrl2_x, e.end_x);
                py[k] = curve_coord(k, pen_y, e.ctrl1_y, e.ctrl2_y, e.end_y);
            end
            px[4] = e.end_x;
            py[4] = e.end_y;
            nseg  = 4;
        end
        for (k = 0; k < nseg; k++)
        begin
            s.from_x = px[k];
            s.from_y = py[k];
            s.to_x   = px[k+1];
            s.to_y   = py[k+1];
            s.last   = (k == nseg - 1);
            if (keep)
                pending_segs = {pending_segs, s};
        end
        pen_x = e.end_x;
        pen_y = e.end_y;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Coordinates are taken as plain numbers and cut to the coordinate width.
    function automatic void add_row(input kind_t k, input bit pf,
                                    input longint cx,
                                    input longint cy,
                                    input longint c1x,
                                    input longint c1y,
                                    input longint c2x,
                                    input longint c2y,
                                    input longint ex,
                                    input longint ey,
                                    input int typed_n);
        plan_row_t r;
        r.e       = '{k, pf, CW'(cx), CW'(cy), CW'(c1x), CW'(c1y),
                      CW'(c2x), CW'(c2y), CW'(ex), CW'(ey)};
        r.typed_n = typed_n;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_typed(input longint fx,
                                      input longint fy,
                                      input longint tx,
                                      input longint ty,
                                      input bit fin);
        segment_t s;
        s = '{CW'(fx), CW'(fy), CW'(tx), CW'(ty), fin};
        typed_segs = {typed_segs, s};
    endfunction

    // Coordinates: the range limits, the full range, and a small window
    // around zero where the rounding of the curve points is easy to hit.
    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3:    return CW'($urandom());
            default: return CW'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // Offers one element and holds it until the block takes it. Returns at
    // the falling edge after the transfer.
    task automatic send_element(input element_t e, input int typed_n);
        segment_t s;
        kind       <= e.kind;
        path_first <= e.path_first;
        close_x    <= e.close_x;
        close_y    <= e.close_y;
        ctrl1_x    <= e.ctrl1_x;
        ctrl1_y    <= e.ctrl1_y;
        ctrl2_x    <= e.ctrl2_x;
        ctrl2_y    <= e.ctrl2_y;
        end_x      <= e.end_x;
        end_y      <= e.end_y;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (typed_n == 0)
        begin
            flatten_element(e, 1'b1);
        end
        else
        begin
            // Hand-typed rows still move the pen so later rows stay in step.
            flatten_element(e, 1'b0);
            repeat (typed_n)
            begin
                s = typed_segs.pop_front();
                pending_segs = {pending_segs, s};
            end
        end
        elem_sent++;
        if (e.kind == KIND_CORNER)
            corner_sent++;
        else
            curve_sent++;
        if (e.path_first)
            path_starts++;
        @(negedge clk);
    endtask

    // Idles the input channel for a random gap, or not at all.
    task automatic idle_input(input bit allow);
        int gap;
        gap = allow ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string what, input segment_t want,
                                input segment_t got);
        error_count++;
        if (error_count <= REPORT_MAX)
        begin
            $display("ERROR %s: expected (%0d,%0d)->(%0d,%0d) last %0d,",
                     what, want.from_x, want.from_y, want.to_x, want.to_y, want.last);
            $display("      got (%0d,%0d)->(%0d,%0d) last %0d",
                     got.from_x, got.from_y, got.to_x, got.to_y, got.last);
        end
    endtask

    task automatic check_segment(input segment_t got);
        segment_t want;
        if (pending_segs.size() == 0)
        begin
            report_error("segment with nothing owed", '0, got);
        end
        else
        begin
            want = pending_segs.pop_front();
            seg_checked++;
            if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
                got.to_x !== want.to_x || got.to_y !== want.to_y ||
                got.last !== want.last)
                report_error("segment mismatch", want, got);
        end
    endtask

    // Every output transfer is compared with the oldest owed segment. The
    // sample is taken at the rising edge, before the block's registers move.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
                check_segment('{from_x, from_y, to_x, to_y, last});
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // Stall is changed on the falling edge only. A hold request from the
    // sender makes the receiver refuse everything for a long stretch, which
    // fills both stages of the block and backs up its input.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (steady)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    // Counts cycles in which neither channel completes a transfer. A stuck
    // handshake or a missing segment runs this out.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR watchdog: no transfer for %0d cycles, %0d segments owed",
                 QUIET_LIMIT, pending_segs.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        element_t e;
        int       sent;
        int       path_left;
        bit       in_burst;

        error_count = 0;
        seg_checked = 0;
        elem_sent   = 0;
        corner_sent = 0;
        curve_sent  = 0;
        path_starts = 0;
        hold_req    = 1'b0;
        steady      = 1'b0;
        pen_x       = '0;
        pen_y       = '0;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = 1'b0;
        path_first = 1'b0;
        close_x    = '0;
        close_y    = '0;
        ctrl1_x    = '0;
        ctrl1_y    = '0;
        ctrl2_x    = '0;
        ctrl2_y    = '0;
        end_x      = '0;
        end_y      = '0;

        // Directed table. Rows with typed segments are the ones that can be
        // read off by eye; the rest go through the model.

        // A corner straight after reset with no path start: the pen is at
        // the origin, and both the closing point and ctrl1 are ignored.
        add_row(KIND_CORNER, 1'b0, 24'h123456, 24'h654321, C_MAX, C_MIN,
                256, 512, 768, -256, 2);
        add_typed(0, 0, 256, 512, 1'b0);
        add_typed(256, 512, 768, -256, 1'b1);
        // A corner between the range limits, starting a path.
        add_row(KIND_CORNER, 1'b1, C_MAX, C_MIN, C_MIN, C_MAX,
                C_MIN, C_MAX, C_MAX, C_MAX, 2);
        add_typed(C_MAX, C_MIN, C_MIN, C_MAX, 1'b0);
        add_typed(C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
        // A curve collapsed onto the most negative point, then onto the
        // most positive one: every curve point stays on it exactly.
        add_row(KIND_CURVE, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN,
                C_MIN, C_MIN, C_MIN, C_MIN, 4);
        repeat (3) add_typed(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
        add_typed(C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
        add_row(KIND_CURVE, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX,
                C_MAX, C_MAX, C_MAX, C_MAX, 4);
        repeat (3) add_typed(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
        add_typed(C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
        // A corner through the origin between -1 and +1.
        add_row(KIND_CORNER, 1'b1, -1, -1, 7, 7, 0, 0, 1, 1, 2);
        add_typed(-1, -1, 0, 0, 1'b0);
        add_typed(0, 0, 1, 1, 1'b1);
        // Full swing curves continuing from the kept pen position.
        add_row(KIND_CURVE, 1'b0, 0, 0, C_MIN, C_MIN, C_MIN, C_MIN,
                C_MIN, C_MIN, 0);
        add_row(KIND_CURVE, 1'b0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                C_MAX, C_MIN, 0);
        // Rounding ties of either sign on small curves.
        add_row(KIND_CURVE, 1'b1, 0, 0, 0, 0, 0, 0, 32, -32, 0);
        add_row(KIND_CURVE, 1'b1, 0, 0, 0, 0, 0, 0, -32, 32, 0);
        add_row(KIND_CURVE, 1'b1, 1, -1, -1, 1, 1, -1, -1, 1, 0);
        add_row(KIND_CURVE, 1'b0, 5, 9, 63, -63, -96, 96, 31, -33, 0);
        // Alternating bit patterns in every coordinate.
        add_row(KIND_CURVE, 1'b1, 24'h555555, 24'hAAAAAA, 24'hAAAAAA,
                24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 0);
        add_row(KIND_CORNER, 1'b0, 24'hAAAAAA, 24'h555555, 24'h555555,
                24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 0);
        // A path whose first element lacks the start flag: the curve takes
        // off from where the previous element ended.
        add_row(KIND_CURVE, 1'b0, C_MIN, C_MAX, C_MAX, 0, C_MIN, 0, 0, 0, 0);
        add_row(KIND_CORNER, 1'b0, C_MAX, C_MAX, 0, 0, -4096, 4095, 12, -12, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_element(directed_rows[i].e, directed_rows[i].typed_n);
            idle_input(1'b1);
        end

        // Let the directed part drain before the random paths begin.
        in_valid <= 1'b0;
        while (pending_segs.size() != 0) @(negedge clk);

        // Random part: mostly closed paths that begin with the start flag
        // and continue from the kept pen position, with some elements whose
        // start flag is random.
        sent      = 0;
        path_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            in_burst = (sent >= BURST_AT && sent < BURST_AT + BURST_LEN);
            if (sent == BURST_AT)
                hold_req = 1'b1;
            steady = (sent >= STEADY_FROM && sent < STEADY_TO);

            e.kind    = $urandom_range(0, 1) ? KIND_CURVE : KIND_CORNER;
            e.close_x = pick_coord();
            e.close_y = pick_coord();
            e.ctrl1_x = pick_coord();
            e.ctrl1_y = pick_coord();
            e.ctrl2_x = pick_coord();
            e.ctrl2_y = pick_coord();
            e.end_x   = pick_coord();
            e.end_y   = pick_coord();
            if (path_left == 0)
            begin
                path_left    = $urandom_range(1, 6);
                e.path_first = ($urandom_range(0, 9) != 0);
            end
            else
            begin
                e.path_first = ($urandom_range(0, 9) == 0);
            end
            path_left--;

            send_element(e, 0);
            sent++;

            if (sent == PAUSE_AT)
            begin
                // The sender waits for every owed segment before going on.
                in_valid <= 1'b0;
                while (pending_segs.size() != 0) @(negedge clk);
            end
            else
            begin
                idle_input(!in_burst && !steady);
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d elements: %0d corners, %0d curves, %0d path starts.",
                 elem_sent, corner_sent, curve_sent, path_starts);
        $display("Checked %0d segments, %0d errors, including a long output hold-off.",
                 seg_checked, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ocf_pkg.sv
rtl/outline_curve_flattener_top.sv
rtl/ocf_checker.sv
tb/testbench.sv
